// ===== rtl/core/bls_pkg.sv =====
`default_nettype none
package bls_pkg;

	localparam int COORD_BITS  = 12;
	localparam int ERR_BITS    = COORD_BITS + 2;
	localparam int COLOR_BITS  = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_STEP = 1'b1
	} action_t;

	typedef struct packed {
		action_t                      action;
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
		logic [COLOR_BITS-1:0]        line_color;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] pixel_x;
		logic signed [COORD_BITS-1:0] pixel_y;
		logic [COLOR_BITS-1:0]        pixel_color;
		logic                         last_pixel;
	} out_item_t;

	// classified command handed from front to back
	typedef struct packed {
		action_t               action;
		logic [COORD_BITS-1:0] start_x;
		logic [COORD_BITS-1:0] start_y;
		logic [COORD_BITS-1:0] delta_major;
		logic [COORD_BITS-1:0] delta_minor;
		logic                  x_dir_neg;
		logic                  y_dir_neg;
		logic                  x_is_major;
		logic [COLOR_BITS-1:0] color;
	} cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/bls_front.sv =====
`default_nettype none
module bls_front import bls_pkg::*; (
	input  in_item_t item,
	output cmd_t     cmd
);

	logic signed [COORD_BITS:0] diff_x;
	logic signed [COORD_BITS:0] diff_y;
	logic signed [COORD_BITS:0] abs_x;
	logic signed [COORD_BITS:0] abs_y;
	logic [COORD_BITS-1:0]      dx;
	logic [COORD_BITS-1:0]      dy;
	logic                       x_major;

	always_comb begin
		diff_x  = $signed({item.end_x[COORD_BITS-1], item.end_x})
			- $signed({item.start_x[COORD_BITS-1], item.start_x});
		diff_y  = $signed({item.end_y[COORD_BITS-1], item.end_y})
			- $signed({item.start_y[COORD_BITS-1], item.start_y});
		abs_x   = diff_x[COORD_BITS] ? -diff_x : diff_x;
		abs_y   = diff_y[COORD_BITS] ? -diff_y : diff_y;
		dx      = abs_x[COORD_BITS-1:0];
		dy      = abs_y[COORD_BITS-1:0];
		x_major = dx > dy;

		cmd.action      = item.action;
		cmd.start_x     = item.start_x;
		cmd.start_y     = item.start_y;
		cmd.delta_major = x_major ? dx : dy;
		cmd.delta_minor = x_major ? dy : dx;
		cmd.x_dir_neg   = !(item.start_x < item.end_x);
		cmd.y_dir_neg   = !(item.start_y < item.end_y);
		cmd.x_is_major  = x_major;
		cmd.color       = item.line_color;
	end

endmodule
`default_nettype wire

// ===== rtl/core/bls_queue.sv =====
`default_nettype none
module bls_queue import bls_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_stall,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_stall,
	output cmd_t pop_cmd
);

	cmd_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 push;
	logic                 pop;

	assign push_stall = count_q == QCNT_BITS'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/bls_back.sv =====
`default_nettype none
module bls_back import bls_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_t      cmd,
	output logic      pixel_valid,
	input  logic      pixel_stall,
	output out_item_t pixel
);

	logic [COORD_BITS-1:0] cur_x_q;
	logic [COORD_BITS-1:0] cur_y_q;
	logic [COORD_BITS-1:0] delta_major_q;
	logic [COORD_BITS-1:0] delta_minor_q;
	logic                  x_dir_neg_q;
	logic                  y_dir_neg_q;
	logic                  x_is_major_q;
	logic [ERR_BITS-1:0]   err_acc_q;
	logic [COORD_BITS-1:0] steps_left_q;
	logic [COLOR_BITS-1:0] held_color_q;
	logic                  pixel_valid_q;
	out_item_t             pixel_q;

	logic                  out_free;
	logic                  busy;
	logic                  take;
	logic                  emit;
	logic [ERR_BITS-1:0]   err_sum;
	logic [ERR_BITS-1:0]   err_red;
	logic                  minor_step;
	logic                  step_x;
	logic                  step_y;
	logic [COORD_BITS-1:0] next_x;
	logic [COORD_BITS-1:0] next_y;
	logic [COORD_BITS-1:0] next_steps;

	assign out_free = !pixel_valid_q || !pixel_stall;
	assign busy     = steps_left_q != '0;
	assign cmd_stall = cmd.action == ACT_STEP && busy && !out_free;
	assign take      = cmd_valid && !cmd_stall;
	assign emit      = take && cmd.action == ACT_STEP && busy;

	always_comb begin
		err_sum    = err_acc_q + ERR_BITS'(delta_minor_q);
		err_red    = err_sum - ERR_BITS'(delta_major_q);
		minor_step = err_sum > ERR_BITS'(delta_major_q);
		step_x     = x_is_major_q || minor_step;
		step_y     = !x_is_major_q || minor_step;
		next_x     = step_x ? (x_dir_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1) : cur_x_q;
		next_y     = step_y ? (y_dir_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1) : cur_y_q;
		next_steps = steps_left_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			delta_major_q <= '0;
			delta_minor_q <= '0;
			x_dir_neg_q   <= 1'b0;
			y_dir_neg_q   <= 1'b0;
			x_is_major_q  <= 1'b0;
			err_acc_q     <= '0;
			steps_left_q  <= '0;
			held_color_q  <= '0;
			pixel_valid_q <= 1'b0;
		end else begin
			if (take && cmd.action == ACT_LOAD) begin
				cur_x_q       <= cmd.start_x;
				cur_y_q       <= cmd.start_y;
				delta_major_q <= cmd.delta_major;
				delta_minor_q <= cmd.delta_minor;
				x_dir_neg_q   <= cmd.x_dir_neg;
				y_dir_neg_q   <= cmd.y_dir_neg;
				x_is_major_q  <= cmd.x_is_major;
				err_acc_q     <= ERR_BITS'(cmd.delta_major >> 1);
				steps_left_q  <= cmd.delta_major;
				held_color_q  <= cmd.color;
			end else if (emit) begin
				cur_x_q      <= next_x;
				cur_y_q      <= next_y;
				err_acc_q    <= minor_step ? err_red : err_sum;
				steps_left_q <= next_steps;
			end
			if (emit) begin
				pixel_valid_q <= 1'b1;
			end else if (!pixel_stall) begin
				pixel_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_q.pixel_x     <= next_x;
			pixel_q.pixel_y     <= next_y;
			pixel_q.pixel_color <= held_color_q;
			pixel_q.last_pixel  <= next_steps == '0;
		end
	end

	assign pixel_valid = pixel_valid_q;
	assign pixel       = pixel_q;

`ifndef NO_ASSERTIONS
	a_err_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		err_acc_q <= ERR_BITS'(delta_major_q))
		else $error("error term above major delta");

	a_steps_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		steps_left_q <= delta_major_q)
		else $error("step count above major delta");

	a_minor_le_major: assert property (@(posedge clk) disable iff (!arst_n)
		delta_minor_q <= delta_major_q)
		else $error("minor delta above major delta");

	a_emit_counts: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> steps_left_q == $past(steps_left_q) - 1'b1)
		else $error("step count did not advance on emitted pixel");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/bresenham_line_stepper.sv =====
`default_nettype none
// An accepted item is written into the command queue, read by the back end;
// the pixel of a step item is then registered in the output register.
// Throughput: one item per cycle when nothing stalls, set by the back-end step;
// a 2-entry command queue decouples input and output stalls.
// Reset (arst_n low): queue emptied, output invalid, stepper idle with no line.
module bresenham_line_stepper import bls_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      pixel_valid,
	input  logic      pixel_stall,
	output out_item_t pixel
);

	cmd_t front_cmd;
	cmd_t queue_cmd;
	logic queue_valid;
	logic queue_stall;

	bls_front u_front (
		.item (item),
		.cmd  (front_cmd)
	);

	bls_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (item_valid),
		.push_stall (item_stall),
		.push_cmd   (front_cmd),
		.pop_valid  (queue_valid),
		.pop_stall  (queue_stall),
		.pop_cmd    (queue_cmd)
	);

	bls_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (queue_valid),
		.cmd_stall   (queue_stall),
		.cmd         (queue_cmd),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel)
	);

endmodule
`default_nettype wire
